// File: rtl/core/edg_pkg.sv
package edg_pkg;

  localparam int unsigned OpW   = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;

  typedef enum logic [OpW-1:0] {
    OP_ADC16 = 4'd0,
    OP_SBC16 = 4'd1,
    OP_NEG   = 4'd2,
    OP_RRD   = 4'd3,
    OP_RLD   = 4'd4,
    OP_LDI   = 4'd5,
    OP_LDD   = 4'd6,
    OP_LDIR  = 4'd7,
    OP_LDDR  = 4'd8
  } op_e;

  localparam logic [ByteW-1:0] FlS  = 8'h80;
  localparam logic [ByteW-1:0] FlZ  = 8'h40;
  localparam logic [ByteW-1:0] Fl5  = 8'h20;
  localparam logic [ByteW-1:0] FlH  = 8'h10;
  localparam logic [ByteW-1:0] Fl3  = 8'h08;
  localparam logic [ByteW-1:0] FlPv = 8'h04;
  localparam logic [ByteW-1:0] FlN  = 8'h02;
  localparam logic [ByteW-1:0] FlC  = 8'h01;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] flags_in;
    logic [WordW-1:0] hl_in;
    logic [WordW-1:0] pair_operand;
    logic [WordW-1:0] dest_in;
    logic [WordW-1:0] count_in;
    logic [ByteW-1:0] mem_byte;
  } cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] acc_out;
    logic [ByteW-1:0] flags_out;
    logic [WordW-1:0] hl_out;
    logic [WordW-1:0] dest_out;
    logic [WordW-1:0] count_out;
    logic [ByteW-1:0] mem_data_out;
    logic             mem_write;
    logic             repeat_res;
    logic [WordW-1:0] wz_out;
    logic             wz_write;
  } res_t;

endpackage

// File: rtl/core/edg_if.sv
interface edg_in_if import edg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [ByteW-1:0] acc;
  logic [ByteW-1:0] flags_in;
  logic [WordW-1:0] hl_in;
  logic [WordW-1:0] pair_operand;
  logic [WordW-1:0] dest_in;
  logic [WordW-1:0] count_in;
  logic [ByteW-1:0] mem_byte;

  modport source (
    output valid, op, acc, flags_in, hl_in, pair_operand, dest_in, count_in, mem_byte,
    input  ready
  );
  modport sink (
    input  valid, op, acc, flags_in, hl_in, pair_operand, dest_in, count_in, mem_byte,
    output ready
  );
endinterface

interface edg_out_if import edg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] acc_out;
  logic [ByteW-1:0] flags_out;
  logic [WordW-1:0] hl_out;
  logic [WordW-1:0] dest_out;
  logic [WordW-1:0] count_out;
  logic [ByteW-1:0] mem_data_out;
  logic             mem_write;
  logic             repeat_res;
  logic [WordW-1:0] wz_out;
  logic             wz_write;

  modport source (
    output valid, acc_out, flags_out, hl_out, dest_out, count_out, mem_data_out,
           mem_write, repeat_res, wz_out, wz_write,
    input  ready
  );
  modport sink (
    input  valid, acc_out, flags_out, hl_out, dest_out, count_out, mem_data_out,
           mem_write, repeat_res, wz_out, wz_write,
    output ready
  );
endinterface

// File: rtl/core/ed_group_execute_unit_top.sv
// Execute unit for the ED-prefixed group: 16-bit ADC/SBC on HL, NEG, RRD/RLD
// and the block copies LDI/LDD/LDIR/LDDR, computed from the register values
// carried in each input word. One word is accepted per cycle unless both registers
// are full and the output is not ready; a word goes through the input register,
// then the result register, and both registers advance together whenever the
// result register is empty or being taken. Unknown op codes pass all registers
// through with no memory write, no repeat and no memptr update; unused
// mem_data_out and wz_out are 0.
module ed_group_execute_unit_top import edg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  edg_in_if.sink     in_i,
  edg_out_if.source  out_o
);

  logic cmd_vld_q, res_vld_q;
  logic adv_res, adv_cmd;
  cmd_t cmd_q;
  res_t res_d, res_q;

  assign adv_res  = !res_vld_q || out_o.ready;
  assign adv_cmd  = !cmd_vld_q || adv_res;
  assign in_i.ready = adv_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (adv_cmd) cmd_vld_q <= in_i.valid;
      if (adv_res) res_vld_q <= cmd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_cmd && in_i.valid) begin
      cmd_q <= '{op: in_i.op, acc: in_i.acc, flags_in: in_i.flags_in,
                 hl_in: in_i.hl_in, pair_operand: in_i.pair_operand,
                 dest_in: in_i.dest_in, count_in: in_i.count_in,
                 mem_byte: in_i.mem_byte};
    end
    if (adv_res && cmd_vld_q) res_q <= res_d;
  end

  always_comb begin
    logic             cin;
    logic [WordW:0]   sum17;
    logic [12:0]      half13;
    logic [WordW-1:0] r16;
    logic             ov;
    logic [ByteW-1:0] fl;
    logic [ByteW-1:0] neg8;
    logic [ByteW-1:0] nsum;
    logic [ByteW-1:0] a_new;
    logic [WordW-1:0] bc_dec;
    logic             down;

    cin    = cmd_q.flags_in[0];
    sum17  = '0;
    half13 = '0;
    r16    = '0;
    ov     = 1'b0;
    fl     = '0;
    neg8   = 8'd0 - cmd_q.acc;
    nsum   = cmd_q.mem_byte + cmd_q.acc;
    a_new  = cmd_q.acc;
    bc_dec = cmd_q.count_in - 16'd1;
    down   = 1'b0;

    res_d.acc_out      = cmd_q.acc;
    res_d.flags_out    = cmd_q.flags_in;
    res_d.hl_out       = cmd_q.hl_in;
    res_d.dest_out     = cmd_q.dest_in;
    res_d.count_out    = cmd_q.count_in;
    res_d.mem_data_out = '0;
    res_d.mem_write    = 1'b0;
    res_d.repeat_res   = 1'b0;
    res_d.wz_out       = '0;
    res_d.wz_write     = 1'b0;

    case (op_e'(cmd_q.op))
      OP_ADC16, OP_SBC16: begin
        if (op_e'(cmd_q.op) == OP_SBC16) begin
          sum17  = {1'b0, cmd_q.hl_in} - {1'b0, cmd_q.pair_operand} - {16'd0, cin};
          half13 = {1'b0, cmd_q.hl_in[11:0]} - {1'b0, cmd_q.pair_operand[11:0]}
                   - {12'd0, cin};
          r16    = sum17[WordW-1:0];
          ov     = (cmd_q.hl_in[15] ^ cmd_q.pair_operand[15]) & (cmd_q.hl_in[15] ^ r16[15]);
          fl     = FlN;
        end else begin
          sum17  = {1'b0, cmd_q.hl_in} + {1'b0, cmd_q.pair_operand} + {16'd0, cin};
          half13 = {1'b0, cmd_q.hl_in[11:0]} + {1'b0, cmd_q.pair_operand[11:0]}
                   + {12'd0, cin};
          r16    = sum17[WordW-1:0];
          ov     = ~(cmd_q.hl_in[15] ^ cmd_q.pair_operand[15]) & (cmd_q.hl_in[15] ^ r16[15]);
          fl     = '0;
        end
        if (half13[12]) fl = fl | FlH;
        if (sum17[WordW]) fl = fl | FlC;
        if (r16 == '0) fl = fl | FlZ;
        if (ov) fl = fl | FlPv;
        fl = fl | (r16[15:8] & (FlS | Fl5 | Fl3));
        res_d.hl_out    = r16;
        res_d.flags_out = fl;
        res_d.wz_out    = cmd_q.hl_in + 16'd1;
        res_d.wz_write  = 1'b1;
      end
      OP_NEG: begin
        fl = FlN | (neg8 & (FlS | Fl5 | Fl3));
        if (neg8 == '0) fl = fl | FlZ;
        if (cmd_q.acc[3:0] != 4'd0) fl = fl | FlH;
        if (cmd_q.acc == 8'h80) fl = fl | FlPv;
        if (cmd_q.acc != '0) fl = fl | FlC;
        res_d.acc_out   = neg8;
        res_d.flags_out = fl;
      end
      OP_RRD, OP_RLD: begin
        if (op_e'(cmd_q.op) == OP_RRD) begin
          res_d.mem_data_out = {cmd_q.acc[3:0], cmd_q.mem_byte[7:4]};
          a_new = {cmd_q.acc[7:4], cmd_q.mem_byte[3:0]};
        end else begin
          res_d.mem_data_out = {cmd_q.mem_byte[3:0], cmd_q.acc[3:0]};
          a_new = {cmd_q.acc[7:4], cmd_q.mem_byte[7:4]};
        end
        fl = a_new & (FlS | Fl5 | Fl3);
        if (a_new == '0) fl = fl | FlZ;
        if (~^a_new) fl = fl | FlPv;
        if (cin) fl = fl | FlC;
        res_d.acc_out   = a_new;
        res_d.flags_out = fl;
        res_d.mem_write = 1'b1;
        res_d.wz_out    = cmd_q.hl_in + 16'd1;
        res_d.wz_write  = 1'b1;
      end
      OP_LDI, OP_LDD, OP_LDIR, OP_LDDR: begin
        down = (op_e'(cmd_q.op) == OP_LDD) || (op_e'(cmd_q.op) == OP_LDDR);
        fl = cmd_q.flags_in & (FlS | FlZ | FlC);
        if (nsum[3]) fl = fl | Fl3;
        if (nsum[1]) fl = fl | Fl5;
        if (bc_dec != '0) begin
          fl = fl | FlPv;
          res_d.repeat_res = (op_e'(cmd_q.op) == OP_LDIR) || (op_e'(cmd_q.op) == OP_LDDR);
        end
        res_d.hl_out       = down ? cmd_q.hl_in - 16'd1 : cmd_q.hl_in + 16'd1;
        res_d.dest_out     = down ? cmd_q.dest_in - 16'd1 : cmd_q.dest_in + 16'd1;
        res_d.count_out    = bc_dec;
        res_d.flags_out    = fl;
        res_d.mem_data_out = cmd_q.mem_byte;
        res_d.mem_write    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid        = res_vld_q;
  assign out_o.acc_out      = res_q.acc_out;
  assign out_o.flags_out    = res_q.flags_out;
  assign out_o.hl_out       = res_q.hl_out;
  assign out_o.dest_out     = res_q.dest_out;
  assign out_o.count_out    = res_q.count_out;
  assign out_o.mem_data_out = res_q.mem_data_out;
  assign out_o.mem_write    = res_q.mem_write;
  assign out_o.repeat_res   = res_q.repeat_res;
  assign out_o.wz_out       = res_q.wz_out;
  assign out_o.wz_write     = res_q.wz_write;

endmodule
